[hw/rtl/ers_pkg.sv]
// shared constants and types for the endpoint restore sequencer
// no dependencies
package ers_pkg;

  localparam int unsigned NumParamsDef  = 256;
  localparam int unsigned NumVoicesDef  = 8;
  localparam int unsigned SlotsDef      = 32;
  localparam int unsigned QueueDepthDef = 4;
  localparam logic [15:0] TimeoutRst    = 16'd30000;
  localparam logic [7:0]  FullMask      = 8'hff;

  localparam logic [2:0] FUNC_ENQ   = 3'd0;
  localparam logic [2:0] FUNC_TICK  = 3'd1;
  localparam logic [2:0] FUNC_READY = 3'd2;
  localparam logic [2:0] FUNC_ACK   = 3'd3;
  localparam logic [2:0] FUNC_MAP   = 3'd4;

  localparam logic [2:0] MSG_NONE   = 3'd0;
  localparam logic [2:0] MSG_BEGIN  = 3'd1;
  localparam logic [2:0] MSG_FRONT  = 3'd2;
  localparam logic [2:0] MSG_MORPH  = 3'd3;
  localparam logic [2:0] MSG_REPORT = 3'd4;
  localparam logic [2:0] MSG_DONE   = 3'd5;

  typedef struct packed {
    logic [2:0] func;
    logic       kit_id;
    logic [7:0] voice_mask;
    logic       report_morph;
    logic [2:0] map_voice;
    logic [4:0] map_slot;
    logic [8:0] map_param;
  } req_word_t;

  typedef struct packed {
    logic [2:0] message;
    logic       out_kit;
    logic [8:0] param_index;
    logic       busy_res;
    logic [2:0] queued;
    logic       last;
  } res_word_t;

  typedef struct packed {
    logic       report;
    logic [7:0] mask;
    logic       masked;
    logic       kit;
  } rq_t;

endpackage

[hw/rtl/ers_stream_if.sv]
// valid/ready channel carrying one word of type word_t
// no dependencies; the word type is given by the word_t parameter
interface ers_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/endpoint_restore_sequencer.sv]
// endpoint restore sequencer: request queue, restore phase machine, slot map memory
// depends on ers_pkg and ers_stream_if
//
// usage: words arrive on in_if (enqueue, service tick, ready, ack, map load).
// each word yields one or two result words on out_if; the last one has last set.
// the slot map is a 256 entry synchronous memory, the queue a small memory.
// a word is taken in, then processed; a masked service tick scans one map
// slot per cycle while it walks the voices in its mask.
// one word is worked on at a time; in_if.ready is low until all its results
// have been taken from the output register.
// while out_if.ready is low the result holds and no further progress is made.
// reset clears the phase, queue pointers, cursors and flags and sets the
// wait timeout to 30000; map and queue contents are undefined until written.
// cfg_we_i writes wait_timeout from cfg_wdata_i.
module endpoint_restore_sequencer
  import ers_pkg::*;
#(
  parameter int unsigned NUM_PARAMS      = NumParamsDef,
  parameter int unsigned NUM_VOICES      = NumVoicesDef,
  parameter int unsigned SLOTS_PER_VOICE = SlotsDef,
  parameter int unsigned QUEUE_DEPTH     = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  ers_stream_if.sink   in_if,
  ers_stream_if.source out_if
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_QRD   = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_OUT1  = 3'd4;
  localparam logic [2:0] ST_OUT2  = 3'd5;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_WRDY  = 3'd1;
  localparam logic [2:0] PH_FRONT = 3'd2;
  localparam logic [2:0] PH_MORPH = 3'd3;
  localparam logic [2:0] PH_WACK  = 3'd4;

  localparam logic [8:0] NP = 9'(NUM_PARAMS);
  localparam logic [3:0] NV = 4'(NUM_VOICES);
  localparam logic [5:0] NS = 6'(SLOTS_PER_VOICE);
  localparam logic [2:0] QD = 3'(QUEUE_DEPTH);

  logic [2:0]  st_q, st_d;
  logic [15:0] tmo_q;
  req_word_t   req_q;
  rq_t         rq_mem [4];
  rq_t         rq_rd_q;
  logic [1:0]  head_q, head_d;
  logic [2:0]  cnt_q, cnt_d;
  rq_t         cur_q, cur_d;
  logic [2:0]  ph_q, ph_d;
  logic [8:0]  pcur_q, pcur_d;
  logic [3:0]  vcur_q, vcur_d;
  logic [5:0]  scur_q, scur_d;
  logic [15:0] wcnt_q, wcnt_d;
  logic        rdy_q, rdy_d, ack_q, ack_d;
  logic [8:0]  map_mem [256];
  logic [8:0]  map_rd_q;
  logic        map_pend_q, map_pend_d;
  res_word_t   r1_q, r1_d, r2_q, r2_d;
  logic        two_q, two_d;
  logic        q_we;
  logic [1:0]  q_wa, q_ra;
  rq_t         q_wd;
  logic        m_re;
  logic [7:0]  m_ra;

  function automatic logic [1:0] qmod(input logic [3:0] x);
    logic [3:0] r;
    r = x;
    if (r >= 4'(QD)) r = r - 4'(QD);
    if (r >= 4'(QD)) r = r - 4'(QD);
    return r[1:0];
  endfunction

  function automatic res_word_t mk(input logic [2:0] m, input logic k, input logic [8:0] i);
    res_word_t r;
    r = '0;
    r.message = m;
    r.out_kit = (m == MSG_NONE) ? 1'b0 : k;
    r.param_index = (m == MSG_FRONT || m == MSG_MORPH) ? i : 9'd0;
    return r;
  endfunction

  assign in_if.ready = (st_q == ST_IDLE);
  assign out_if.valid = (st_q == ST_OUT1) || (st_q == ST_OUT2);
  assign out_if.data = (st_q == ST_OUT2) ? r2_q : r1_q;

  always_ff @(posedge clk_i) begin
    if (q_we) rq_mem[q_wa] <= q_wd;
    rq_rd_q <= rq_mem[q_ra];
    if (st_q == ST_EXEC && req_q.func == FUNC_MAP &&
        {1'b0, req_q.map_voice} < NV && {1'b0, req_q.map_slot} < NS)
      map_mem[{req_q.map_voice, req_q.map_slot}] <= req_q.map_param;
    if (m_re) map_rd_q <= map_mem[m_ra];
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) req_q <= in_if.data;
    r1_q <= r1_d;
    r2_q <= r2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      tmo_q <= TimeoutRst;
      head_q <= '0;
      cnt_q <= '0;
      cur_q <= '0;
      ph_q <= PH_IDLE;
      pcur_q <= '0;
      vcur_q <= '0;
      scur_q <= '0;
      wcnt_q <= '0;
      rdy_q <= 1'b0;
      ack_q <= 1'b0;
      map_pend_q <= 1'b0;
      two_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) tmo_q <= cfg_wdata_i;
      head_q <= head_d;
      cnt_q <= cnt_d;
      cur_q <= cur_d;
      ph_q <= ph_d;
      pcur_q <= pcur_d;
      vcur_q <= vcur_d;
      scur_q <= scur_d;
      wcnt_q <= wcnt_d;
      rdy_q <= rdy_d;
      ack_q <= ack_d;
      map_pend_q <= map_pend_d;
      two_q <= two_d;
    end
  end

  always_comb begin
    logic [1:0] tail;
    logic       masked;
    rq_t        nr;
    logic       hit;
    logic [2:0] smsg;
    st_d = st_q;
    head_d = head_q; cnt_d = cnt_q; cur_d = cur_q; ph_d = ph_q;
    pcur_d = pcur_q; vcur_d = vcur_q; scur_d = scur_q; wcnt_d = wcnt_q;
    rdy_d = rdy_q; ack_d = ack_q; map_pend_d = 1'b0;
    r1_d = r1_q; r2_d = r2_q; two_d = two_q;
    q_we = 1'b0; q_wa = '0; q_wd = '0; m_re = 1'b0; m_ra = '0;
    tail = qmod(4'(head_q) + 4'(cnt_q) - 4'd1);
    q_ra = (req_q.func == FUNC_TICK) ? head_q : tail;
    masked = (req_q.voice_mask != FullMask);
    nr.kit = req_q.kit_id; nr.masked = masked;
    nr.mask = req_q.voice_mask; nr.report = req_q.report_morph;
    hit = 1'b0;
    smsg = (ph_q == PH_FRONT) ? MSG_FRONT : MSG_MORPH;
    case (st_q)
      ST_IDLE: begin
        if (in_if.valid) st_d = ST_QRD;
      end
      ST_QRD: st_d = ST_EXEC;
      ST_EXEC: begin
        r1_d = mk(MSG_NONE, 1'b0, '0);
        two_d = 1'b0;
        st_d = ST_OUT1;
        case (req_q.func)
          FUNC_ENQ: begin
            if (req_q.voice_mask != 8'd0) begin
              if (cnt_q != 3'd0 && rq_rd_q.kit == nr.kit && rq_rd_q.masked == masked) begin
                q_we = 1'b1; q_wa = tail; q_wd = rq_rd_q;
                if (masked) q_wd.mask = rq_rd_q.mask | nr.mask;
                if (nr.report) q_wd.report = 1'b1;
              end else if (cnt_q >= QD) begin
                q_we = 1'b1; q_wa = tail; q_wd = nr;
              end else begin
                q_we = 1'b1; q_wa = qmod(4'(head_q) + 4'(cnt_q)); q_wd = nr;
                cnt_d = cnt_q + 3'd1;
              end
            end
          end
          FUNC_READY: rdy_d = 1'b1;
          FUNC_ACK: ack_d = 1'b1;
          FUNC_TICK: begin
            case (ph_q)
              PH_IDLE: begin
                if (cnt_q != 3'd0) begin
                  cur_d = rq_rd_q;
                  head_d = qmod(4'(head_q) + 4'd1);
                  cnt_d = cnt_q - 3'd1;
                  pcur_d = '0; vcur_d = '0; scur_d = '0; wcnt_d = '0;
                  rdy_d = 1'b0; ack_d = 1'b0;
                  r1_d = mk(MSG_BEGIN, rq_rd_q.kit, '0);
                  ph_d = PH_WRDY;
                end
              end
              PH_WRDY: begin
                if (rdy_q) begin
                  pcur_d = '0; vcur_d = '0; scur_d = '0; wcnt_d = '0;
                  ph_d = PH_FRONT;
                end else if (wcnt_q < tmo_q) begin
                  wcnt_d = wcnt_q + 16'd1;
                end else begin
                  r1_d = mk(MSG_DONE, cur_q.kit, '0);
                  cur_d = '0; pcur_d = '0; vcur_d = '0; scur_d = '0; wcnt_d = '0;
                  ph_d = PH_IDLE;
                end
              end
              PH_FRONT, PH_MORPH: st_d = ST_SCAN;
              PH_WACK: begin
                if (ack_q || wcnt_q >= tmo_q) begin
                  cur_d = '0; pcur_d = '0; vcur_d = '0; scur_d = '0; wcnt_d = '0;
                  ph_d = PH_IDLE;
                end else begin
                  wcnt_d = wcnt_q + 16'd1;
                end
              end
              default: begin
                cur_d = '0; pcur_d = '0; vcur_d = '0; scur_d = '0; wcnt_d = '0;
                ph_d = PH_IDLE;
              end
            endcase
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (!cur_q.masked) begin
          if (pcur_q < NP) begin
            hit = 1'b1;
            r1_d = mk(smsg, cur_q.kit, pcur_q);
            pcur_d = pcur_q + 9'd1;
          end
        end else if (map_pend_q) begin
          if (map_rd_q < NP) begin
            hit = 1'b1;
            r1_d = mk(smsg, cur_q.kit, map_rd_q);
          end
        end
        if (hit) begin
          two_d = 1'b0;
          st_d = ST_OUT1;
        end else if (cur_q.masked && vcur_q < NV) begin
          if (!cur_q.mask[vcur_q[2:0]] || scur_q >= NS) begin
            vcur_d = vcur_q + 4'd1;
            scur_d = '0;
          end else begin
            m_re = 1'b1;
            m_ra = {vcur_q[2:0], scur_q[4:0]};
            scur_d = scur_q + 6'd1;
            map_pend_d = 1'b1;
          end
        end else if (!map_pend_q) begin
          pcur_d = '0; vcur_d = '0; scur_d = '0;
          if (ph_q == PH_FRONT) begin
            ph_d = PH_MORPH;
            r1_d = mk(MSG_NONE, 1'b0, '0);
            two_d = 1'b0;
          end else begin
            ack_d = 1'b0;
            wcnt_d = '0;
            ph_d = PH_WACK;
            if (cur_q.report) begin
              r1_d = mk(MSG_REPORT, cur_q.kit, '0);
              r2_d = mk(MSG_DONE, cur_q.kit, '0);
              two_d = 1'b1;
            end else begin
              r1_d = mk(MSG_DONE, cur_q.kit, '0);
              two_d = 1'b0;
            end
          end
          st_d = ST_OUT1;
        end
      end
      ST_OUT1: begin
        if (out_if.ready) st_d = two_q ? ST_OUT2 : ST_IDLE;
      end
      ST_OUT2: begin
        if (out_if.ready) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
    if (st_q == ST_EXEC || st_q == ST_SCAN) begin
      r1_d.busy_res = (ph_d != PH_IDLE) || (cnt_d != 3'd0);
      r1_d.queued = cnt_d;
      r1_d.last = !two_d;
      r2_d.busy_res = r1_d.busy_res;
      r2_d.queued = cnt_d;
      r2_d.last = 1'b1;
    end
  end

endmodule
